>>> hw/rtl/dahdsr_envelope_generator_core_defines.svh
// assertion helpers used by the envelope core rtl
`ifndef DAHDSR_ENVELOPE_GENERATOR_CORE_DEFINES_SVH
`define DAHDSR_ENVELOPE_GENERATOR_CORE_DEFINES_SVH

// same-cycle implication
`define DAHDSR_ASSERT_IMP(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define DAHDSR_ASSERT_NXT(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/dahdsr_pkg.sv
package dahdsr_pkg;

  localparam int AMP_W       = 25;  // amplitude, q1.24
  localparam int AMP_FRAC    = 24;
  localparam int RATE_W      = 32;  // rates, q2.30
  localparam int RATE_FRAC   = 30;
  localparam int DIGIT_W_DEF = 4;   // multiplier digit, must divide RATE_W

  typedef struct packed {
    logic busy;
    logic done;
  } mul_stat_t;

endpackage

>>> hw/rtl/dahdsr_mul.sv
module dahdsr_mul #(
  parameter int AW = dahdsr_pkg::AMP_W,
  parameter int BW = dahdsr_pkg::RATE_W,
  parameter int DW = dahdsr_pkg::DIGIT_W_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic [AW-1:0]           a,
  input  logic [BW-1:0]           b,
  output dahdsr_pkg::mul_stat_t   stat,
  output logic [AW+BW-1:0]        prod
);
  import dahdsr_pkg::*;

  localparam int STEPS = BW / DW;
  localparam int CNT_W = $clog2(STEPS + 1);

  logic [AW+BW-1:0] acc;
  logic [AW-1:0]    a_reg;
  logic [CNT_W-1:0] cnt;
  logic             done_r;
  logic [AW+DW-1:0] sum;

  // lsb-first shift-add: one digit of b per cycle, b shifts out as the product shifts in
  always_comb begin
    sum = (AW+DW)'(acc[AW+BW-1:BW]) + (AW+DW)'(a_reg) * (AW+DW)'(acc[DW-1:0]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt    <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= (cnt == CNT_W'(1));
      if (start) begin
        cnt <= CNT_W'(STEPS);
      end else if (cnt != '0) begin
        cnt <= cnt - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc   <= {{AW{1'b0}}, b};
      a_reg <= a;
    end else if (cnt != '0) begin
      acc <= {sum, acc[BW-1:DW]};
    end
  end

  assign stat.busy = (cnt != '0);
  assign stat.done = done_r;
  assign prod      = acc;

endmodule

>>> hw/rtl/dahdsr_envelope_generator_core.sv
// channel   dir  tdata                                         tuser
// s_*       in   [15:0] sample_in, [47:16] release_rate,       [1:0] kind
//                [71:48] release_samples
// m_*       out  [15:0] sample_out                             [0] end_of_sound, [3:1] phase
// cfg_*     in   cfg_index picks the register, cfg_data holds the value
//
// a sample word while enabled passes the amplitude multiply (when phase scaling applies) and the
// sample multiply before the output stage; other words go straight to the output stage.
// the next word can be accepted in the same cycle as the previous one is presented.
// the shared digit-serial multiplier runs amplitude times rate when phase scaling applies, then sample times amplitude.
// one word is in flight at a time; s_tready is high only while the engine is idle.
// a stalled output holds the finished word in the output stage; the engine waits behind it.
// rst is synchronous: phase off, amplitude and counters zero, registers at their defaults.
module dahdsr_envelope_generator_core #(
  parameter int DIGIT_W = dahdsr_pkg::DIGIT_W_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [71:0] s_tdata,   // sample_in, release_rate, release_samples
  input  logic [1:0]  s_tuser,   // kind
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // sample_out
  output logic [3:0]  m_tuser    // end_of_sound, phase
);
  import dahdsr_pkg::*;

  localparam int LEN_W  = 24;
  localparam int MAG_W  = 17;
  localparam int PROD_W = AMP_W + RATE_W;
  localparam int SCL_W  = PROD_W - RATE_FRAC;
  localparam int SMP_W  = PROD_W - AMP_FRAC;

  localparam logic [1:0] KIND_SAMPLE  = 2'd0;
  localparam logic [1:0] KIND_NOTE_ON = 2'd1;
  localparam logic [1:0] KIND_RELEASE = 2'd2;

  localparam logic [2:0] REG_DELAY  = 3'd0;
  localparam logic [2:0] REG_ATTACK = 3'd1;
  localparam logic [2:0] REG_HOLD   = 3'd2;
  localparam logic [2:0] REG_DECAY  = 3'd3;
  localparam logic [2:0] REG_A_RATE = 3'd4;
  localparam logic [2:0] REG_D_RATE = 3'd5;
  localparam logic [2:0] REG_PEAK   = 3'd6;
  localparam logic [2:0] REG_ENABLE = 3'd7;

  localparam logic [2:0] PH_DELAY   = 3'd0;
  localparam logic [2:0] PH_ATTACK  = 3'd1;
  localparam logic [2:0] PH_HOLD    = 3'd2;
  localparam logic [2:0] PH_DECAY   = 3'd3;
  localparam logic [2:0] PH_SUSTAIN = 3'd4;
  localparam logic [2:0] PH_RELEASE = 3'd5;
  localparam logic [2:0] PH_OFF     = 3'd6;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_AMP  = 2'd1;
  localparam logic [1:0] ST_SMP  = 2'd2;
  localparam logic [1:0] ST_OUT  = 2'd3;

  localparam logic [AMP_W-1:0] ATTACK_START = AMP_W'(1677);
  localparam logic [RATE_W-1:0] RATE_ONE    = RATE_W'(1073741824);
  localparam logic [AMP_W-1:0] PEAK_ONE     = AMP_W'(16777216);

  // configuration
  logic [LEN_W-1:0]  delay_samples, attack_samples, hold_samples, decay_samples;
  logic [RATE_W-1:0] attack_rate, decay_rate;
  logic [AMP_W-1:0]  peak_level;
  logic              enable;

  // envelope state
  logic [2:0]        cur_phase;
  logic [AMP_W-1:0]  amplitude;
  logic [LEN_W-1:0]  delay_left, attack_left, hold_left, decay_left, release_left;
  logic [RATE_W-1:0] rel_rate;

  logic [1:0]        state;
  logic [MAG_W-1:0]  mag_r;
  logic              neg_r;
  logic [15:0]       res_sample;
  logic              res_eos;

  logic              accept;
  logic [1:0]        kind;
  logic [15:0]       sample_in;
  logic [MAG_W-1:0]  mag_in;

  // phase walk for one sample
  logic [2:0]        ph_next;
  logic [AMP_W-1:0]  amp_sel, amp_clamp;
  logic              do_mul, eos_s, fin;
  logic [RATE_W-1:0] rate_sel;
  logic              dec_delay, dec_attack, dec_hold, dec_decay, dec_release;

  logic              mul_start;
  logic [AMP_W-1:0]  mul_a;
  logic [RATE_W-1:0] mul_b;
  mul_stat_t         mul_stat;
  logic [PROD_W-1:0] mul_prod;

  logic [SCL_W-1:0]  scaled;
  logic [AMP_W-1:0]  amp_scaled;
  logic [SMP_W-1:0]  smp_mag;
  logic [MAG_W-1:0]  smp_sat;
  logic [15:0]       smp_res;

  assign s_tready  = (state == ST_IDLE);
  assign accept    = s_tvalid && s_tready;
  assign kind      = s_tuser;
  assign sample_in = s_tdata[15:0];
  assign mag_in    = sample_in[15] ? (MAG_W'(17'h10000) - MAG_W'(sample_in))
                                   : MAG_W'(sample_in);

  always_comb begin
    ph_next     = cur_phase;
    amp_sel     = amplitude;
    do_mul      = 1'b0;
    rate_sel    = attack_rate;
    eos_s       = 1'b0;
    fin         = 1'b0;
    dec_delay   = 1'b0;
    dec_attack  = 1'b0;
    dec_hold    = 1'b0;
    dec_decay   = 1'b0;
    dec_release = 1'b0;
    if (ph_next == PH_DELAY) begin
      if (delay_left != '0) begin
        dec_delay = 1'b1;
        amp_sel   = '0;
        fin       = 1'b1;
      end else begin
        ph_next = PH_ATTACK;
        amp_sel = ATTACK_START;
      end
    end
    if (!fin && ph_next == PH_ATTACK) begin
      if (attack_left != '0) begin
        dec_attack = 1'b1;
        do_mul     = 1'b1;
        rate_sel   = attack_rate;
        fin        = 1'b1;
      end else begin
        ph_next = PH_HOLD;
        amp_sel = peak_level;
      end
    end
    if (!fin && ph_next == PH_HOLD) begin
      if (hold_left != '0) begin
        dec_hold = 1'b1;
        fin      = 1'b1;
      end else begin
        ph_next = PH_DECAY;
      end
    end
    if (!fin && ph_next == PH_DECAY) begin
      if (decay_left != '0) begin
        dec_decay = 1'b1;
        do_mul    = 1'b1;
        rate_sel  = decay_rate;
        fin       = 1'b1;
      end else begin
        ph_next = PH_SUSTAIN;
      end
    end
    if (!fin && ph_next == PH_SUSTAIN) begin
      fin = 1'b1;
    end
    if (!fin && ph_next == PH_RELEASE) begin
      if (release_left != '0) begin
        dec_release = 1'b1;
        do_mul      = 1'b1;
        rate_sel    = rel_rate;
        fin         = 1'b1;
      end else begin
        ph_next = PH_OFF;
        amp_sel = '0;
      end
    end
    if (!fin) begin
      ph_next = PH_OFF;
      eos_s   = 1'b1;
    end
    amp_clamp = (amp_sel > peak_level) ? peak_level : amp_sel;
  end

  // amplitude times rate, truncated then clamped to peak
  assign scaled     = mul_prod[PROD_W-1:RATE_FRAC];
  assign amp_scaled = (scaled > SCL_W'(peak_level)) ? peak_level : scaled[AMP_W-1:0];

  // sample magnitude times amplitude, truncated toward zero then saturated
  assign smp_mag = mul_prod[PROD_W-1:AMP_FRAC];
  always_comb begin
    if (neg_r) begin
      smp_sat = (smp_mag > SMP_W'(32768)) ? MAG_W'(32768) : smp_mag[MAG_W-1:0];
      smp_res = 16'(MAG_W'(0) - smp_sat);
    end else begin
      smp_sat = (smp_mag > SMP_W'(32767)) ? MAG_W'(32767) : smp_mag[MAG_W-1:0];
      smp_res = smp_sat[15:0];
    end
  end

  always_comb begin
    mul_start = 1'b0;
    mul_a     = amp_clamp;
    mul_b     = do_mul ? rate_sel : RATE_W'(mag_in);
    if (accept && kind == KIND_SAMPLE && enable) begin
      mul_start = 1'b1;
    end
    if (state == ST_AMP && mul_stat.done) begin
      mul_start = 1'b1;
      mul_a     = amp_scaled;
      mul_b     = RATE_W'(mag_r);
    end
  end

  dahdsr_mul #(
    .AW (AMP_W),
    .BW (RATE_W),
    .DW (DIGIT_W)
  ) u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .stat  (mul_stat),
    .prod  (mul_prod)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      delay_samples  <= '0;
      attack_samples <= '0;
      hold_samples   <= '0;
      decay_samples  <= '0;
      attack_rate    <= RATE_ONE;
      decay_rate     <= RATE_ONE;
      peak_level     <= PEAK_ONE;
      enable         <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_DELAY:  delay_samples  <= cfg_data[LEN_W-1:0];
        REG_ATTACK: attack_samples <= cfg_data[LEN_W-1:0];
        REG_HOLD:   hold_samples   <= cfg_data[LEN_W-1:0];
        REG_DECAY:  decay_samples  <= cfg_data[LEN_W-1:0];
        REG_A_RATE: attack_rate    <= cfg_data[RATE_W-1:0];
        REG_D_RATE: decay_rate     <= cfg_data[RATE_W-1:0];
        REG_PEAK:   peak_level     <= cfg_data[AMP_W-1:0];
        REG_ENABLE: enable         <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      cur_phase    <= PH_OFF;
      amplitude    <= '0;
      delay_left   <= '0;
      attack_left  <= '0;
      hold_left    <= '0;
      decay_left   <= '0;
      release_left <= '0;
      rel_rate     <= '0;
      m_tvalid     <= 1'b0;
    end else begin
      // the output stage reloads in ST_OUT, so only clear it elsewhere
      if (m_tvalid && m_tready && state != ST_OUT) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            state <= ST_OUT;
            case (kind)
              KIND_NOTE_ON: begin
                delay_left  <= delay_samples;
                attack_left <= attack_samples;
                hold_left   <= hold_samples;
                decay_left  <= decay_samples;
                cur_phase   <= PH_DELAY;
                amplitude   <= '0;
              end
              KIND_RELEASE: begin
                if (enable) begin
                  rel_rate     <= s_tdata[47:16];
                  release_left <= s_tdata[71:48];
                  cur_phase    <= PH_RELEASE;
                end
              end
              KIND_SAMPLE: begin
                if (enable) begin
                  cur_phase <= ph_next;
                  if (dec_delay)   delay_left   <= delay_left - LEN_W'(1);
                  if (dec_attack)  attack_left  <= attack_left - LEN_W'(1);
                  if (dec_hold)    hold_left    <= hold_left - LEN_W'(1);
                  if (dec_decay)   decay_left   <= decay_left - LEN_W'(1);
                  if (dec_release) release_left <= release_left - LEN_W'(1);
                  if (!do_mul) amplitude <= amp_clamp;
                  state <= do_mul ? ST_AMP : ST_SMP;
                end
              end
              default: ;
            endcase
          end
        end
        ST_AMP: begin
          if (mul_stat.done) begin
            amplitude <= amp_scaled;
            state     <= ST_SMP;
          end
        end
        ST_SMP: begin
          if (mul_stat.done) begin
            state <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            state    <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // word payload, no reset needed
  always_ff @(posedge clk) begin
    if (accept) begin
      mag_r <= mag_in;
      neg_r <= sample_in[15];
      if (kind == KIND_SAMPLE && !enable) begin
        res_sample <= sample_in;
      end else begin
        res_sample <= '0;
      end
      if (kind == KIND_RELEASE) begin
        res_eos <= !enable;
      end else if (kind == KIND_SAMPLE) begin
        res_eos <= enable && eos_s;
      end else begin
        res_eos <= 1'b0;
      end
    end else if (state == ST_SMP && mul_stat.done) begin
      res_sample <= smp_res;
    end
    if (state == ST_OUT && (!m_tvalid || m_tready)) begin
      m_tdata <= res_sample;
      m_tuser <= {cur_phase, res_eos};
    end
  end

`include "dahdsr_envelope_generator_core_defines.svh"

  `DAHDSR_ASSERT_IMP(a_idle_mul_free, clk, rst, s_tready, !mul_stat.busy, "multiplier busy while idle")
  `DAHDSR_ASSERT_NXT(a_amp_to_smp, clk, rst, (state == ST_AMP) && mul_stat.done, (state == ST_SMP) && mul_stat.busy, "sample multiply did not follow scaling")
  `DAHDSR_ASSERT_NXT(a_out_load, clk, rst, (state == ST_OUT) && (!m_tvalid || m_tready), m_tvalid && (state == ST_IDLE), "finished word not presented")

endmodule

>>> verif/dahdsr_envelope_generator_core_checker.sv
`timescale 1ns / 100ps

package dahdsr_tb_pkg;

  typedef enum logic [1:0] {
    KIND_SAMPLE  = 2'd0,
    KIND_NOTE_ON = 2'd1,
    KIND_KEY_OFF = 2'd2,
    KIND_SPARE   = 2'd3
  } word_kind_e;

  typedef enum logic [2:0] {
    REG_DELAY_LEN   = 3'd0,
    REG_ATTACK_LEN  = 3'd1,
    REG_HOLD_LEN    = 3'd2,
    REG_DECAY_LEN   = 3'd3,
    REG_ATTACK_RATE = 3'd4,
    REG_DECAY_RATE  = 3'd5,
    REG_PEAK        = 3'd6,
    REG_ENABLE      = 3'd7
  } reg_index_e;

  typedef enum logic [2:0] {
    PH_DELAY   = 3'd0,
    PH_ATTACK  = 3'd1,
    PH_HOLD    = 3'd2,
    PH_DECAY   = 3'd3,
    PH_SUSTAIN = 3'd4,
    PH_RELEASE = 3'd5,
    PH_OFF     = 3'd6
  } env_phase_e;

  localparam logic [24:0] ATTACK_FLOOR = 25'd1677;  // 0.0001 in q1.24, truncated
  localparam logic [24:0] LEVEL_ONE    = 25'h100_0000;
  localparam logic [31:0] RATE_ONE     = 32'h4000_0000;

endpackage

module dahdsr_envelope_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [71:0] s_tdata,
  input  logic [1:0]  s_tuser,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [15:0] m_tdata,
  input  logic [3:0]  m_tuser,
  output int          expected_left,
  output int          errors
);
  import dahdsr_tb_pkg::*;

  typedef struct packed {
    logic [15:0] sample;
    logic        eos;
    env_phase_e  phase;
  } env_word_t;

  // register copy
  logic [23:0] len_delay, len_attack, len_hold, len_decay;
  logic [31:0] attack_mult, decay_mult;
  logic [24:0] peak_r;
  logic        active;

  // envelope state
  env_phase_e  cur_phase;
  logic [24:0] level;
  logic [23:0] left_delay, left_attack, left_hold, left_decay, left_release;
  logic [31:0] release_mult;

  env_word_t awaited_words[$];
  env_word_t want;

  function automatic logic [24:0] clamp_level(input logic [63:0] v);
    return (v > {39'd0, peak_r}) ? peak_r : v[24:0];
  endfunction

  function automatic logic [24:0] scale_level(input logic [24:0] lvl, input logic [31:0] rate);
    logic [63:0] prod;
    prod = ({39'd0, lvl} * {32'd0, rate}) >> dahdsr_pkg::RATE_FRAC;
    return clamp_level(prod);
  endfunction

  // sign-magnitude product, truncated toward zero, then saturated
  function automatic logic [15:0] apply_level(input logic [15:0] raw, input logic [24:0] lvl);
    logic [63:0] mag;
    logic [63:0] neg_word;
    mag = raw[15] ? (64'd65536 - {48'd0, raw}) : {48'd0, raw};
    mag = (mag * {39'd0, lvl}) >> dahdsr_pkg::AMP_FRAC;
    if (raw[15]) begin
      if (mag > 64'd32768) mag = 64'd32768;
      neg_word = 64'd65536 - mag;
      return neg_word[15:0];
    end
    if (mag > 64'd32767) mag = 64'd32767;
    return mag[15:0];
  endfunction

  function automatic env_word_t shape_word(input word_kind_e kind, input logic [15:0] smp,
                                           input logic [31:0] rel_rate,
                                           input logic [23:0] rel_len);
    env_word_t  w;
    env_phase_e p;
    logic [24:0] amp;
    logic       finished;
    w = '0;
    case (kind)
      KIND_NOTE_ON: begin
        left_delay  = len_delay;
        left_attack = len_attack;
        left_hold   = len_hold;
        left_decay  = len_decay;
        cur_phase   = PH_DELAY;
        level       = '0;
      end
      KIND_KEY_OFF: begin
        if (!active) begin
          w.eos = 1'b1;
        end else begin
          release_mult = rel_rate;
          left_release = rel_len;
          cur_phase    = PH_RELEASE;
        end
      end
      KIND_SAMPLE: begin
        if (!active) begin
          w.sample = smp;
        end else begin
          p = cur_phase;
          amp = level;
          finished = 1'b0;
          // an expired phase hands the same word on to the next one
          if (p == PH_DELAY) begin
            if (left_delay != 0) begin
              left_delay--;
              amp = '0;
              finished = 1'b1;
            end else begin
              p = PH_ATTACK;
              amp = ATTACK_FLOOR;
            end
          end
          if (!finished && p == PH_ATTACK) begin
            if (left_attack != 0) begin
              left_attack--;
              amp = scale_level(clamp_level(amp), attack_mult);
              finished = 1'b1;
            end else begin
              p = PH_HOLD;
              amp = peak_r;
            end
          end
          if (!finished && p == PH_HOLD) begin
            if (left_hold != 0) begin
              left_hold--;
              finished = 1'b1;
            end else begin
              p = PH_DECAY;
            end
          end
          if (!finished && p == PH_DECAY) begin
            if (left_decay != 0) begin
              left_decay--;
              amp = scale_level(clamp_level(amp), decay_mult);
              finished = 1'b1;
            end else begin
              p = PH_SUSTAIN;
            end
          end
          if (!finished && p == PH_SUSTAIN) finished = 1'b1;
          if (!finished && p == PH_RELEASE) begin
            if (left_release != 0) begin
              left_release--;
              amp = scale_level(clamp_level(amp), release_mult);
              finished = 1'b1;
            end else begin
              p = PH_OFF;
              amp = '0;
            end
          end
          if (!finished) begin
            p = PH_OFF;
            w.eos = 1'b1;
          end
          cur_phase = p;
          level = clamp_level(amp);
          w.sample = apply_level(smp, level);
        end
      end
      default: ;
    endcase
    w.phase = cur_phase;
    return w;
  endfunction

  task automatic copy_register(input logic [2:0] idx, input logic [31:0] val);
    case (reg_index_e'(idx))
      REG_DELAY_LEN:   len_delay = val[23:0];
      REG_ATTACK_LEN:  len_attack = val[23:0];
      REG_HOLD_LEN:    len_hold = val[23:0];
      REG_DECAY_LEN:   len_decay = val[23:0];
      REG_ATTACK_RATE: attack_mult = val;
      REG_DECAY_RATE:  decay_mult = val;
      REG_PEAK:        peak_r = val[24:0];
      REG_ENABLE:      active = val[0];
      default: ;
    endcase
  endtask

  task automatic report_mismatch(input string what);
    if (errors < 100) $display("ERROR %0t: %s", $time, what);
    errors++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      len_delay = '0;
      len_attack = '0;
      len_hold = '0;
      len_decay = '0;
      attack_mult = RATE_ONE;
      decay_mult = RATE_ONE;
      peak_r = LEVEL_ONE;
      active = 1'b1;
      cur_phase = PH_OFF;
      level = '0;
      left_delay = '0;
      left_attack = '0;
      left_hold = '0;
      left_decay = '0;
      left_release = '0;
      release_mult = '0;
      awaited_words.delete();
    end else begin
      if (cfg_we) copy_register(cfg_index, cfg_data);
      // check outgoing word before queuing the incoming one
      if (m_tvalid && m_tready) begin
        if (awaited_words.size() == 0) begin
          report_mismatch($sformatf("output word with nothing awaited, sample_out %0d",
                                    $signed(m_tdata)));
        end else begin
          want = awaited_words.pop_front();
          if (m_tdata !== want.sample)
            report_mismatch($sformatf("sample_out got %0d expected %0d",
                                      $signed(m_tdata), $signed(want.sample)));
          if (m_tuser[0] !== want.eos)
            report_mismatch($sformatf("end_of_sound got %b expected %b", m_tuser[0], want.eos));
          if (m_tuser[3:1] !== want.phase)
            report_mismatch($sformatf("phase got %0d expected %0d", m_tuser[3:1], want.phase));
        end
      end
      if (s_tvalid && s_tready)
        awaited_words.push_back(shape_word(word_kind_e'(s_tuser), s_tdata[15:0],
                                           s_tdata[47:16], s_tdata[71:48]));
    end
    expected_left = awaited_words.size();
  end

endmodule

>>> verif/dahdsr_envelope_generator_core_test.sv
`timescale 1ns / 100ps

module dahdsr_envelope_generator_core_test;
  import dahdsr_tb_pkg::*;

  localparam int RANDOM_WORDS      = 1800;
  localparam int WORDS_PER_SETTING = 150;
  localparam int STALL_LIMIT       = 4000;
  localparam int HOLD_OFF_CYCLES   = 600;

  typedef enum int {STALL_NONE, STALL_HALF, STALL_MOSTLY, STALL_RARE} stall_mode_e;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [71:0] s_tdata = '0;   // sample_in, release_rate, release_samples
  logic [1:0]  s_tuser = '0;   // kind
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;        // sample_out
  logic [3:0]  m_tuser;        // end_of_sound, phase

  int expected_left;
  int errors;
  int idle_cycles = 0;
  int words_sent = 0;
  int burst_left = 0;
  logic [31:0] setting [8];

  always #2 clk = ~clk;

  dahdsr_envelope_generator_core dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

  dahdsr_envelope_checker envelope_check (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_tvalid      (s_tvalid),
    .s_tready      (s_tready),
    .s_tdata       (s_tdata),
    .s_tuser       (s_tuser),
    .m_tvalid      (m_tvalid),
    .m_tready      (m_tready),
    .m_tdata       (m_tdata),
    .m_tuser       (m_tuser),
    .expected_left (expected_left),
    .errors        (errors)
  );

  always @(posedge clk) begin
    if (rst || cfg_we || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : watchdog
    wait (idle_cycles >= STALL_LIMIT);
    $display("Simulation FAILED");
    $finish;
  end

  initial begin : receiver
    stall_mode_e mode;
    int stretch;
    int rounds;
    int hold_offs;
    rounds = 0;
    hold_offs = 0;
    forever begin
      mode = stall_mode_e'($urandom_range(0, 3));
      stretch = $urandom_range(16, 96);
      repeat (stretch) begin
        @(posedge clk);
        case (mode)
          STALL_NONE:   m_tready <= 1'b1;
          STALL_HALF:   m_tready <= ($urandom_range(0, 1) == 1);
          STALL_MOSTLY: m_tready <= ($urandom_range(0, 7) == 0);
          default:      m_tready <= ($urandom_range(0, 7) != 0);
        endcase
      end
      rounds++;
      // long hold-off so the block backs up and drops s_tready
      if (rounds % 40 == 0 && hold_offs < 3) begin
        hold_offs++;
        @(posedge clk);
        m_tready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end
    end
  end

  task automatic send_word(input word_kind_e kind, input logic [15:0] smp,
                           input logic [31:0] rate, input logic [23:0] len);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tdata <= {len, rate, smp};
    s_tuser <= kind;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    words_sent++;
  endtask

  // drain everything in flight before touching registers
  task automatic settle();
    s_tvalid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (expected_left != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input reg_index_e idx, input logic [31:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [15:0] pick_sample();
    case ($urandom_range(0, 11))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'h0000;
      3: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [31:0] pick_rate(input logic rising);
    case ($urandom_range(0, 5))
      0: return 32'h0;
      1: return 32'hFFFF_FFFF;
      2: return RATE_ONE;
      3: return $urandom;
      default: return rising ? RATE_ONE + $urandom_range(0, 32'h1000_0000)
                             : RATE_ONE - $urandom_range(0, 32'h1000_0000);
    endcase
  endfunction

  task automatic play_note();
    int span;
    int n_on;
    int n_off;
    logic [23:0] rel_len;
    span = setting[REG_DELAY_LEN] + setting[REG_ATTACK_LEN] + setting[REG_HOLD_LEN]
         + setting[REG_DECAY_LEN];
    if (span > 60) span = 60;
    send_word(KIND_NOTE_ON, 16'($urandom), $urandom, 24'($urandom));
    n_on = $urandom_range(0, span + 3);
    repeat (n_on) send_word(KIND_SAMPLE, pick_sample(), $urandom, 24'($urandom));
    if ($urandom_range(0, 5) != 0) begin
      rel_len = ($urandom_range(0, 5) == 0) ? 24'($urandom) : 24'($urandom_range(0, 8));
      send_word(KIND_KEY_OFF, 16'($urandom), pick_rate(1'b0), rel_len);
      n_off = (rel_len > 8) ? $urandom_range(0, 6) : $urandom_range(0, rel_len + 3);
      repeat (n_off) send_word(KIND_SAMPLE, pick_sample(), $urandom, 24'($urandom));
    end
  endtask

  task automatic send_noise();
    repeat ($urandom_range(1, 4))
      send_word(word_kind_e'($urandom_range(0, 3)), 16'($urandom), $urandom, 24'($urandom));
  endtask

  task automatic pick_setting(input int round);
    for (int i = 0; i < 4; i++)
      setting[i] = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 40) : $urandom_range(0, 6);
    setting[REG_ATTACK_RATE] = pick_rate(1'b1);
    setting[REG_DECAY_RATE] = pick_rate(1'b0);
    case ($urandom_range(0, 5))
      0: setting[REG_PEAK] = LEVEL_ONE;
      1: setting[REG_PEAK] = $urandom_range(0, LEVEL_ONE);
      default: setting[REG_PEAK] = $urandom_range(LEVEL_ONE / 4, LEVEL_ONE);
    endcase
    setting[REG_ENABLE] = 32'($urandom_range(0, 5) != 0);
    case (round)
      0: begin
        for (int i = 0; i < 4; i++) setting[i] = 0;
        setting[REG_ATTACK_RATE] = 32'hFFFF_FFFF;
        setting[REG_DECAY_RATE] = 32'hFFFF_FFFF;
        setting[REG_PEAK] = 32'h01FF_FFFF;
        setting[REG_ENABLE] = 1;
      end
      1: begin
        setting[REG_PEAK] = 0;
        setting[REG_ENABLE] = 1;
      end
      2: setting[REG_ENABLE] = 0;
      default: ;
    endcase
    for (int i = 0; i < 8; i++) write_reg(reg_index_e'(i), setting[i]);
  endtask

  initial begin : stimulus
    int target;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // off after reset, unused kind, then zero lengths fall straight to sustain
    send_word(KIND_SAMPLE, 16'h7FFF, '0, '0);
    send_word(KIND_SPARE, 16'hFFFF, '1, '1);
    send_word(KIND_NOTE_ON, 16'h0000, '0, '0);
    send_word(KIND_SAMPLE, 16'h7FFF, '0, '0);
    send_word(KIND_SAMPLE, 16'h8000, '0, '0);
    send_word(KIND_KEY_OFF, 16'h0000, 32'hFFFF_FFFF, 24'd1);
    send_word(KIND_SAMPLE, 16'h1234, '0, '0);
    send_word(KIND_SAMPLE, 16'hFFFF, '0, '0);
    settle();

    // bypass, release while disabled, note start while disabled
    write_reg(REG_ENABLE, 32'd0);
    send_word(KIND_SAMPLE, 16'hABCD, '0, '0);
    send_word(KIND_KEY_OFF, 16'h0000, 32'h1234_5678, 24'hFF_FFFF);
    send_word(KIND_NOTE_ON, 16'h5555, '1, '1);
    send_word(KIND_SPARE, 16'h0000, '0, '0);
    settle();

    write_reg(REG_ENABLE, 32'd1);
    write_reg(REG_DELAY_LEN, 32'h00FF_FFFF);
    write_reg(REG_ATTACK_LEN, 32'h00FF_FFFF);
    write_reg(REG_HOLD_LEN, 32'h00FF_FFFF);
    write_reg(REG_DECAY_LEN, 32'h00FF_FFFF);
    write_reg(REG_ATTACK_RATE, 32'hFFFF_FFFF);
    write_reg(REG_DECAY_RATE, 32'h0);
    write_reg(REG_PEAK, 32'h01FF_FFFF);
    send_word(KIND_NOTE_ON, 16'h0000, '0, '0);
    send_word(KIND_SAMPLE, 16'h7FFF, '0, '0);
    settle();

    // short attack into a hold above one, output saturates
    write_reg(REG_DELAY_LEN, 32'd0);
    write_reg(REG_ATTACK_LEN, 32'd2);
    send_word(KIND_NOTE_ON, 16'h0000, '0, '0);
    send_word(KIND_SAMPLE, 16'h7FFF, '0, '0);
    send_word(KIND_SAMPLE, 16'h7FFF, '0, '0);
    send_word(KIND_SAMPLE, 16'h7FFF, '0, '0);
    send_word(KIND_SAMPLE, 16'h8000, '0, '0);
    settle();

    write_reg(REG_HOLD_LEN, 32'd0);
    write_reg(REG_DECAY_LEN, 32'd3);
    write_reg(REG_PEAK, 32'd0);
    send_word(KIND_NOTE_ON, 16'h0000, '0, '0);
    send_word(KIND_SAMPLE, 16'h7FFF, '0, '0);
    settle();

    target = words_sent;
    for (int round = 0; round < RANDOM_WORDS / WORDS_PER_SETTING; round++) begin
      pick_setting(round);
      target += WORDS_PER_SETTING;
      while (words_sent < target) begin
        if ($urandom_range(0, 7) == 0) send_noise();
        else play_note();
      end
      settle();
    end

    repeat (40) @(posedge clk);
    if (errors == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule

>>> files.f
+incdir+hw/rtl
hw/rtl/dahdsr_pkg.sv
hw/rtl/dahdsr_mul.sv
hw/rtl/dahdsr_envelope_generator_core.sv
verif/dahdsr_envelope_generator_core_checker.sv
verif/dahdsr_envelope_generator_core_test.sv
